FILE: rtl/tlf_pkg.sv
package tlf_pkg;

   localparam int MAX_COLUMNS = 32;
   localparam int MAX_LINE    = 1000;

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int LEN_W  = $clog2(MAX_COLUMNS + 1);
   localparam int LINE_W = $clog2(MAX_LINE);

   localparam logic [7:0]        NEWLINE    = 8'd10;
   localparam logic [7:0]        BLANK_CODE = 8'd32;
   localparam logic [7:0]        PRINT_LOW  = 8'd32;
   localparam logic [7:0]        PRINT_HIGH = 8'd127;
   localparam logic [6:0]        BLANK      = 7'd32;
   localparam logic [6:0]        NL_CHAR    = 7'd10;
   localparam logic [5:0]        WIDTH_RESET = 6'd20;
   localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(MAX_LINE - 1);

   // write port of the segment buffer
   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic [6:0]       data;
   } buf_wr_type;

   // physical slot of logical position off in the circular segment buffer
   function automatic logic [COL_W-1:0] slot_of(logic [COL_W-1:0] base,
                                                 logic [LEN_W-1:0] off);
      logic [LEN_W:0] sum;
      sum = (LEN_W+1)'(base) + (LEN_W+1)'(off);
      if (int'(sum) >= MAX_COLUMNS) begin
         return COL_W'(sum - (LEN_W+1)'(MAX_COLUMNS));
      end
      return COL_W'(sum);
   endfunction

   // width as used: zero acts as one, large values clip to the buffer size
   function automatic logic [LEN_W-1:0] eff_width(logic [5:0] w);
      if (w == 6'd0) begin
         return LEN_W'(1);
      end else if (int'(w) > MAX_COLUMNS) begin
         return LEN_W'(MAX_COLUMNS);
      end
      return LEN_W'(w);
   endfunction

endpackage

FILE: rtl/tlf_seg_buf.sv
module tlf_seg_buf
   import tlf_pkg::*;
(
   input  logic             clock,
   input  buf_wr_type       wr,
   input  logic [COL_W-1:0] rd_addr,
   output logic [6:0]       rd_data
);

   logic [6:0] mem [MAX_COLUMNS];
   logic [6:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/text_line_folder.sv
// text_line_folder: word wrap of a character stream at a programmable width
//
// req channel: one character word per handshake (tdata = in_char). codes 32..127
// and newline are taken, all others are dropped without output. the block
// holds the current segment in a circular buffer and writes nothing until a
// fold or a line end; then it streams the segment, one word per cycle at most,
// on the rsp channel, followed by a newline word carrying tlast.
// csr channel: write of fold_width, always ready; write it only while idle.
//
// steps per word: a buffered character is written straight into the buffer. a
// newline puts out the segment and then the newline word. a fold searches back
// for a blank, puts out the cut, skips the blanks after it and then stores the
// new character. each probe or output word issues one read on the single buffer
// read port and waits for the registered read data.
// req_tready is low while a fold or line end is in progress.
//
// reset clears the segment, line count and skip flag, sets fold_width to 20
// and empties the output register. a stalled rsp receiver holds the output
// register and pauses the sequencer; nothing is lost.
module text_line_folder
   import tlf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic       rsp_tlast,   // last_of_run
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [5:0] csr_data     // [5:0] fold_width
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_SCAN_ADDR = 9'b000000010,
      ST_SCAN_DATA = 9'b000000100,
      ST_EMIT_ADDR = 9'b000001000,
      ST_EMIT_DATA = 9'b000010000,
      ST_EMIT_NL   = 9'b000100000,
      ST_SKIP_ADDR = 9'b001000000,
      ST_SKIP_DATA = 9'b010000000,
      ST_APPEND    = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [COL_W-1:0]  base_ff, base_in;     // slot of segment position zero
   logic [LEN_W-1:0]  len_ff, len_in;       // characters in the segment
   logic              skip_ff, skip_in;     // dropping blanks after a fold
   logic [LINE_W-1:0] lcc_ff, lcc_in;       // characters taken in this line
   logic [5:0]        width_ff, width_in;
   logic [6:0]        char_ff, char_in;     // character of the current word
   logic [LEN_W-1:0]  idx_ff, idx_in;       // scan / output / skip position
   logic [LEN_W-1:0]  cut_ff, cut_in;       // characters to put out
   logic              fold_ff, fold_in;     // a fold, not a line end

   logic              rsp_valid_ff, rsp_valid_in;
   logic [6:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   buf_wr_type        buf_wr;
   logic [6:0]        rd_data;
   logic [COL_W-1:0]  rd_addr;
   logic [LEN_W-1:0]  w_eff;
   logic              out_free;
   logic              out_load;
   logic [6:0]        out_char;
   logic              out_last;
   logic              printable;
   logic              finish_skip;

   assign w_eff     = eff_width(width_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign printable = (req_tdata >= PRINT_LOW) && (req_tdata <= PRINT_HIGH);
   // reads follow the position counter; the buffer registers the read data, so it shows up in the next cycle
   assign rd_addr   = slot_of(base_ff, idx_ff);

   tlf_seg_buf u_seg_buf (
      .clock   (clock),
      .wr      (buf_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      len_in      = len_ff;
      skip_in     = skip_ff;
      lcc_in      = lcc_ff;
      char_in     = char_ff;
      idx_in      = idx_ff;
      cut_in      = cut_ff;
      fold_in     = fold_ff;
      buf_wr      = '0;
      out_load    = 1'b0;
      out_char    = rd_data;
      out_last    = 1'b0;
      finish_skip = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               char_in = req_tdata[6:0];
               if (req_tdata == NEWLINE) begin
                  // line end: put out the whole segment, then newline
                  cut_in  = len_ff;
                  idx_in  = '0;
                  fold_in = 1'b0;
                  len_in  = '0;
                  skip_in = 1'b0;
                  lcc_in  = '0;
                  if (lcc_ff == '0) begin
                     state_in = ST_EMIT_NL;
                  end else if (len_ff != '0) begin
                     state_in = ST_EMIT_ADDR;
                  end
               end else if (printable && lcc_ff < LINE_LIMIT) begin
                  lcc_in = lcc_ff + LINE_W'(1);
                  if (!(skip_ff && req_tdata == BLANK_CODE)) begin
                     skip_in = 1'b0;
                     if (len_ff >= w_eff) begin
                        // segment full: search back for a blank
                        fold_in = 1'b1;
                        cut_in  = w_eff;
                        if (w_eff == LEN_W'(1)) begin
                           idx_in   = '0;
                           state_in = ST_EMIT_ADDR;
                        end else begin
                           idx_in   = w_eff - LEN_W'(1);
                           state_in = ST_SCAN_ADDR;
                        end
                     end else begin
                        buf_wr.en   = 1'b1;
                        buf_wr.addr = slot_of(base_ff, len_ff);
                        buf_wr.data = req_tdata[6:0];
                        len_in      = len_ff + LEN_W'(1);
                     end
                  end
               end
            end
         end
         ST_SCAN_ADDR: begin
            state_in = ST_SCAN_DATA;
         end
         ST_SCAN_DATA: begin
            if (rd_data == BLANK) begin
               cut_in   = idx_ff + LEN_W'(1);
               idx_in   = '0;
               state_in = ST_EMIT_ADDR;
            end else if (idx_ff == LEN_W'(1)) begin
               // no blank: hard fold at full width
               idx_in   = '0;
               state_in = ST_EMIT_ADDR;
            end else begin
               idx_in   = idx_ff - LEN_W'(1);
               state_in = ST_SCAN_ADDR;
            end
         end
         ST_EMIT_ADDR: begin
            state_in = ST_EMIT_DATA;
         end
         ST_EMIT_DATA: begin
            if (out_free) begin
               out_load = 1'b1;
               if (idx_ff + LEN_W'(1) == cut_ff) begin
                  state_in = ST_EMIT_NL;
               end else begin
                  idx_in   = idx_ff + LEN_W'(1);
                  state_in = ST_EMIT_ADDR;
               end
            end
         end
         ST_EMIT_NL: begin
            if (out_free) begin
               out_load = 1'b1;
               out_char = NL_CHAR;
               out_last = 1'b1;
               if (fold_ff) begin
                  idx_in   = cut_ff;
                  state_in = ST_SKIP_ADDR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SKIP_ADDR: begin
            if (idx_ff >= len_ff) begin
               finish_skip = 1'b1;
            end else begin
               state_in = ST_SKIP_DATA;
            end
         end
         ST_SKIP_DATA: begin
            if (rd_data == BLANK) begin
               idx_in   = idx_ff + LEN_W'(1);
               state_in = ST_SKIP_ADDR;
            end else begin
               finish_skip = 1'b1;
            end
         end
         ST_APPEND: begin
            buf_wr.en   = 1'b1;
            buf_wr.addr = slot_of(base_ff, len_ff);
            buf_wr.data = char_ff;
            len_in      = len_ff + LEN_W'(1);
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // drop the folded part and the skipped blanks by moving the base
      if (finish_skip) begin
         base_in = slot_of(base_ff, idx_ff);
         len_in  = len_ff - idx_ff;
         if (len_ff == idx_ff && char_ff == BLANK) begin
            skip_in  = 1'b1;
            state_in = ST_IDLE;
         end else begin
            state_in = ST_APPEND;
         end
      end
   end

   // output register
   always_comb begin
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = out_char;
         rsp_last_in  = out_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign width_in = (csr_valid && csr_ready) ? csr_data : width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         len_ff       <= '0;
         skip_ff      <= 1'b0;
         lcc_ff       <= '0;
         width_ff     <= WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         len_ff       <= len_in;
         skip_ff      <= skip_in;
         lcc_ff       <= lcc_in;
         width_ff     <= width_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      idx_ff      <= idx_in;
      cut_ff      <= cut_in;
      fold_ff     <= fold_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   // the segment never outgrows the buffer
   assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_COLUMNS))
      else $error("segment length beyond buffer size");

   // every run of output ends in a newline
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[6:0] == NL_CHAR)
      else $error("tlast on a word other than newline");

   // blanks are only skipped while the segment is empty
   assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> len_ff == '0)
      else $error("skipping blanks with a non-empty segment");

   // output position stays inside the part being put out
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_DATA |-> idx_ff < cut_ff)
      else $error("output position past the cut");

endmodule
